/* src/scil_pkg.sv */
// Package for the interpolated sine/cosine lookup.
// Holds fixed-point formats, scale constants and the opcode type.
// No dependencies.
package scil_pkg;

   localparam int ANGLE_W  = 22;
   localparam int VALUE_W  = 16;
   localparam int PHASE_W  = 24;
   localparam int K_W      = 22;
   localparam int PROD_W   = ANGLE_W + K_W;

   // round(2^24 / (2*pi)), applied to a Q5.16 angle.
   localparam logic [K_W-1:0] PHASE_K = 22'd2670177;
   // pi/2 in Q30, used only when the table is built.
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam logic [PHASE_W-1:0] QUARTER_TURN = 24'h400000;
   localparam logic [PROD_W-1:0] PHASE_ROUND = 44'd32768;

   localparam int VALUE_MAX = 16384;
   localparam int VALUE_MIN = -16384;

   typedef enum logic {
      OP_SINE   = 1'b0,
      OP_COSINE = 1'b1
   } opcode_type;

endpackage

/* src/sine_cosine_interpolated_lookup.sv */
// Sine/cosine by table lookup with linear interpolation, five-stage pipeline.
// Depends on scil_pkg for formats, constants and the opcode type.
//
// Usage: req_angle_rad is an angle in radians, signed Q5.16; req_opcode
// selects sine or cosine. rsp_value is the result in signed Q1.14. Both
// channels use valid/stall; a transfer takes place on a rising edge with
// valid high and stall low.
// One item can enter every cycle while req_stall is low. The stages are:
// angle times 1/(2*pi) multiply, phase wrap and table position, table
// read of both neighbors, slope multiply, and the final rounded add into
// the output register.
// A stalled response holds its value. Each stage refills as soon as it
// empties or its content moves on, so bubbles close up and req_stall rises
// only when every stage holds an item and rsp_stall is high.
// Reset (synchronous, active high) empties every stage; the sine table is
// a constant and needs no loading.
module sine_cosine_interpolated_lookup
   import scil_pkg::*;
#(
   parameter int ENTRIES = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [ANGLE_W-1:0] req_angle_rad,
   input  logic                      req_opcode,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_value
);

   localparam int IW    = $clog2(ENTRIES);
   localparam int POS_W = PHASE_W + IW;

   // Constant table of one sine period, built at elaboration.
   logic signed [VALUE_W-1:0] sine_rom [ENTRIES];

   for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_rom
      localparam longint I   = gi;
      localparam longint Q   = (I * 4) / ENTRIES;
      localparam longint R0  = I * 4 - Q * ENTRIES;
      localparam longint R   = ((Q & 1) != 0) ? ENTRIES - R0 : R0;
      localparam longint X   = (R * HALF_PI_Q30 + ENTRIES / 2) / ENTRIES;
      localparam longint X2  = (X * X) >>> 30;
      localparam longint T1  = ((X * X2) >>> 30) / 6;
      localparam longint T2  = ((T1 * X2) >>> 30) / 20;
      localparam longint T3  = ((T2 * X2) >>> 30) / 42;
      localparam longint T4  = ((T3 * X2) >>> 30) / 72;
      localparam longint T5  = ((T4 * X2) >>> 30) / 110;
      localparam longint T6  = ((T5 * X2) >>> 30) / 156;
      localparam longint SUM = X - T1 + T2 - T3 + T4 - T5 + T6;
      localparam longint SP  = (SUM < 0) ? 0 : SUM;
      localparam longint S0  = (SP + 32768) >>> 16;
      localparam longint S   = (S0 > VALUE_MAX) ? VALUE_MAX : S0;
      localparam longint V   = ((Q & 2) != 0) ? -S : S;
      assign sine_rom[gi] = VALUE_W'(V);
   end

   // Stage handshake: a stage loads when it is empty or its item moves on.
   logic move1, move2, move3, move4, move5;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   assign move5 = !v5_ff || !rsp_stall;
   assign move4 = !v4_ff || move5;
   assign move3 = !v3_ff || move4;
   assign move2 = !v2_ff || move3;
   assign move1 = !v1_ff || move2;

   assign req_stall = !move1;
   assign rsp_valid = v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (move1) v1_ff <= req_valid;
         if (move2) v2_ff <= v1_ff;
         if (move3) v3_ff <= v2_ff;
         if (move4) v4_ff <= v3_ff;
         if (move5) v5_ff <= v4_ff;
      end
   end

   // Stage 1: scale the angle to a fraction of a turn.
   logic signed [PROD_W-1:0] prod1_in, prod1_ff;
   opcode_type               op1_ff;

   assign prod1_in = PROD_W'(req_angle_rad) * PROD_W'($signed({1'b0, PHASE_K}));

   always_ff @(posedge clock) begin
      if (move1) begin
         prod1_ff <= prod1_in;
         op1_ff   <= opcode_type'(req_opcode);
      end
   end

   // Stage 2: round and wrap to one turn, add the quarter turn for cosine,
   // then split the table position into index and fraction.
   logic [PROD_W-1:0]  round2;
   logic [PHASE_W-1:0] phase2;
   logic [POS_W-1:0]   pos2;
   logic [IW-1:0]      idx2_in, nxt2_in, idx2_ff, nxt2_ff;
   logic [PHASE_W-1:0] frac2_ff;

   always_comb begin
      round2 = prod1_ff + PHASE_ROUND;
      phase2 = round2[PHASE_W+15:16];
      if (op1_ff == OP_COSINE) begin
         phase2 = phase2 + QUARTER_TURN;
      end
      pos2    = POS_W'({{IW{1'b0}}, phase2} * POS_W'(ENTRIES));
      idx2_in = pos2[POS_W-1:PHASE_W];
      if (idx2_in == IW'(ENTRIES - 1)) begin
         nxt2_in = '0;
      end else begin
         nxt2_in = idx2_in + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (move2) begin
         idx2_ff  <= idx2_in;
         nxt2_ff  <= nxt2_in;
         frac2_ff <= pos2[PHASE_W-1:0];
      end
   end

   // Stage 3: read both neighboring samples.
   logic signed [VALUE_W-1:0] s1_3_ff, s2_3_ff;
   logic [PHASE_W-1:0]        frac3_ff;

   always_ff @(posedge clock) begin
      if (move3) begin
         s1_3_ff  <= sine_rom[idx2_ff];
         s2_3_ff  <= sine_rom[nxt2_ff];
         frac3_ff <= frac2_ff;
      end
   end

   // Stage 4: slope times fraction.
   localparam int SLOPE_W = VALUE_W + 1;
   localparam int MUL_W   = SLOPE_W + PHASE_W + 1;

   logic signed [SLOPE_W-1:0] diff4;
   logic signed [MUL_W-1:0]   mul4_in, mul4_ff;
   logic signed [VALUE_W-1:0] s1_4_ff;

   assign diff4   = SLOPE_W'(s2_3_ff) - SLOPE_W'(s1_3_ff);
   assign mul4_in = MUL_W'(diff4) * MUL_W'($signed({1'b0, frac3_ff}));

   always_ff @(posedge clock) begin
      if (move4) begin
         mul4_ff <= mul4_in;
         s1_4_ff <= s1_3_ff;
      end
   end

   // Stage 5: round half up and add to the lower sample.
   localparam int STEP_W = MUL_W - PHASE_W;

   logic signed [MUL_W-1:0]   round5;
   logic signed [STEP_W-1:0]  step5;
   logic signed [VALUE_W-1:0] value5_in, value5_ff;

   assign round5    = mul4_ff + MUL_W'(1 << (PHASE_W - 1));
   assign step5     = round5[MUL_W-1:PHASE_W];
   assign value5_in = VALUE_W'(STEP_W'(s1_4_ff) + step5);

   always_ff @(posedge clock) begin
      if (move5) begin
         value5_ff <= value5_in;
      end
   end

   assign rsp_value = value5_ff;

endmodule

/* src/scil_check.sv */
// Port-level checks for the interpolated sine/cosine lookup.
// Depends on scil_pkg; bound to sine_cosine_interpolated_lookup below.
module scil_check
   import scil_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [VALUE_W-1:0] rsp_value
);

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // The input side is held off only while a finished result waits.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled response");

   // A stalled response keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_value)))
      else $error("stalled response changed");

   // Interpolation between in-range samples stays in range.
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value >= 16'(VALUE_MIN) && rsp_value <= 16'(VALUE_MAX)))
      else $error("response out of range");

   // An input transfer is never refused while the output side is free.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !rsp_stall) |-> !req_stall)
      else $error("input stalled while output is free");

endmodule

bind sine_cosine_interpolated_lookup scil_check u_scil_check (.*);
